FILE: hdl/eit_pkg.sv
// ----------------------------------------------------------------------------
// Extended interval timer package
// Beat types, sequencer states and fixed constants of the interval timer.
// ----------------------------------------------------------------------------
package eit_pkg;

	localparam int unsigned DIV_STEPS  = 33;
	localparam int unsigned STEP_W     = 6;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	localparam logic [9:0]  US_PER_MS    = 10'd1000;
	localparam logic [7:0]  MAX_DIVISOR  = 8'd255;
	localparam logic [10:0] TICK_RESET   = 11'd128;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic MODE_NORMAL  = 1'b0;
	localparam logic MODE_COMPARE = 1'b1;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_TICK = 1'b1;

	typedef struct packed {
		logic        command;
		logic [22:0] desired_time_ms;
	} eit_in_t;

	typedef struct packed {
		logic        event_res;
		logic [7:0]  counter_value;
		logic [31:0] target_periods;
		logic [7:0]  reload_or_compare;
	} eit_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_TIME,
		S_TOTAL,
		S_DIV_TRY,
		S_CHECK
	} eit_state_t;

endpackage

FILE: hdl/extended_interval_timer.sv
// ----------------------------------------------------------------------------
// Extended interval timer
// 8-bit timer stretched to long intervals by overflow or compare-match counting.
// ----------------------------------------------------------------------------
// Tick beat: result valid the next cycle; one tick per cycle while the result register drains.
// Load beat: one shared restoring divide step runs one bit per cycle, 33 steps.
// Normal-mode load: the result follows the multiply, the 33 divide steps and the split.
// Compare-mode load: after that, one division per divisor tried, 255 down to 2, up to 254 tries.
// Input is not ready during a load; the result register drains independently.
// Reset (arst_n low, asynchronous): timer state cleared, mode 0, tick time 128.
module extended_interval_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  eit_pkg::eit_in_t    item,
	output logic                result_valid,
	input  logic                result_ready,
	output eit_pkg::eit_out_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [10:0]         cfg_data
);
	import eit_pkg::*;

	// Configuration registers
	logic        mode_q;
	logic [10:0] tick_time_q;

	// Timer state
	logic [7:0]  timer_q;
	logic [31:0] period_q;
	logic [31:0] target_q;
	logic [7:0]  rem_ticks_q;
	logic [7:0]  cmp_q;

	// Sequencer and shared divide unit
	eit_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [32:0]       quo_q;     // dividend shifts out at the top, quotient shifts in
	logic [10:0]       rem_q;
	logic [31:0]       total_q;
	logic [7:0]        div_q;     // divisor under trial in compare mode

	logic res_valid_q;
	eit_out_t res_q;

	// Control decode
	logic item_acc, tick_acc, load_acc, res_take;
	logic div_run, last_step;
	logic fin_norm, start_try, fin_found, fin_one, retry;

	// ------------------------------------------------------------------
	// Tick arithmetic: advance the timer and count overflows or matches
	// ------------------------------------------------------------------
	logic [7:0]  tmr_inc;
	logic [31:0] per_inc;
	logic        per_hit;
	logic [7:0]  reload_cur;
	logic        tk_event;
	logic [7:0]  tk_timer;
	logic [31:0] tk_period;

	assign tmr_inc    = timer_q + 8'd1;
	// Saturate the period count at its top value
	assign per_inc    = (period_q == '1) ? period_q : period_q + 32'd1;
	assign per_hit    = (per_inc == target_q);
	assign reload_cur = 8'd0 - rem_ticks_q;

	always_comb begin
		tk_event  = 1'b0;
		tk_timer  = tmr_inc;
		tk_period = period_q;
		if (mode_q == MODE_NORMAL) begin
			if (tmr_inc == 8'd0) begin
				if (per_hit) begin
					tk_event  = 1'b1;
					tk_timer  = reload_cur;
					tk_period = 32'd0;
				end else begin
					tk_period = per_inc;
				end
			end
		end else begin
			if (timer_q == cmp_q) begin
				tk_timer = 8'd0;
				if (per_hit) begin
					tk_event  = 1'b1;
					tk_period = 32'd0;
				end else begin
					tk_period = per_inc;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared divide step: one restoring subtract-and-compare per cycle
	// ------------------------------------------------------------------
	logic [10:0] tick_eff;
	logic [10:0] divisor_c;
	logic [11:0] rem_sh;
	logic [11:0] rem_sub;
	logic        ge;
	logic [10:0] rem_next;

	// A zero tick time counts as one microsecond
	assign tick_eff  = (tick_time_q == 11'd0) ? 11'd1 : tick_time_q;
	assign divisor_c = (state_q == S_DIV_TIME) ? tick_eff : {3'b000, div_q};
	assign rem_sh    = {rem_q, quo_q[32]};
	assign rem_sub   = rem_sh - {1'b0, divisor_c};
	assign ge        = (rem_sh >= {1'b0, divisor_c});
	assign rem_next  = ge ? rem_sub[10:0] : rem_sh[10:0];

	// Saturate the tick total to 32 bits
	logic [31:0] total_c;
	logic [7:0]  nrm_rem;
	logic [31:0] nrm_target;
	logic        nrm_frac;

	assign total_c    = quo_q[32] ? 32'hFFFF_FFFF : quo_q[31:0];
	assign nrm_rem    = total_c[7:0];
	assign nrm_frac   = (nrm_rem != 8'd0);
	assign nrm_target = {8'd0, total_c[31:8]} + {31'd0, nrm_frac};

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (load_acc) state_d = S_DIV_TIME;
			end
			S_DIV_TIME: begin
				if (last_step) state_d = S_TOTAL;
			end
			S_TOTAL: begin
				state_d = (mode_q == MODE_NORMAL) ? S_IDLE : S_DIV_TRY;
			end
			S_DIV_TRY: begin
				if (last_step) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = retry ? S_DIV_TRY : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: control outputs
	// ------------------------------------------------------------------
	always_comb begin
		item_ready = 1'b0;
		cfg_ready  = 1'b0;
		div_run    = 1'b0;
		fin_norm   = 1'b0;
		start_try  = 1'b0;
		fin_found  = 1'b0;
		fin_one    = 1'b0;
		retry      = 1'b0;
		case (state_q)
			S_IDLE: begin
				// Take a new beat once the result register is free or draining
				item_ready = !res_valid_q || result_ready;
				cfg_ready  = 1'b1;
			end
			S_DIV_TIME, S_DIV_TRY: begin
				div_run = 1'b1;
			end
			S_TOTAL: begin
				fin_norm  = (mode_q == MODE_NORMAL);
				start_try = (mode_q == MODE_COMPARE);
			end
			S_CHECK: begin
				fin_found = (rem_q == 11'd0);
				// Trying divisor one always succeeds, so stop at two
				fin_one   = (rem_q != 11'd0) && (div_q == 8'd2);
				retry     = (rem_q != 11'd0) && (div_q != 8'd2);
			end
			default: begin
			end
		endcase
	end

	assign item_acc  = item_valid && item_ready;
	assign tick_acc  = item_acc && (item.command == CMD_TICK);
	assign load_acc  = item_acc && (item.command == CMD_LOAD);
	assign res_take  = res_valid_q && result_ready;
	assign last_step = (step_q == LAST_STEP);

	// ------------------------------------------------------------------
	// Sequencer state, configuration and timer state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			mode_q      <= MODE_NORMAL;
			tick_time_q <= TICK_RESET;
			timer_q     <= 8'd0;
			period_q    <= 32'd0;
			target_q    <= 32'd0;
			rem_ticks_q <= 8'd0;
			cmp_q       <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode_q      <= cfg_data[0];
					CFG_TICK: tick_time_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (div_run) begin
				step_q <= last_step ? '0 : step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end

			if (tick_acc) begin
				timer_q  <= tk_timer;
				period_q <= tk_period;
			end

			if (fin_norm) begin
				target_q    <= nrm_target;
				rem_ticks_q <= nrm_rem;
				if (nrm_frac) timer_q <= 8'd0 - nrm_rem;
			end

			if (fin_found) begin
				target_q <= quo_q[31:0];
				cmp_q    <= div_q - 8'd1;
			end

			if (fin_one) begin
				target_q <= total_q;
				cmp_q    <= 8'd0;
			end

			if (tick_acc || fin_norm || fin_found || fin_one) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Divide unit registers and result payload (no reset needed)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_acc) begin
			// Form the exact product of milliseconds and microseconds per millisecond
			quo_q <= 33'(item.desired_time_ms) * 33'(US_PER_MS);
			rem_q <= 11'd0;
		end else if (div_run) begin
			quo_q <= {quo_q[31:0], ge};
			rem_q <= rem_next;
		end else if (start_try || retry) begin
			quo_q <= start_try ? {1'b0, total_c} : {1'b0, total_q};
			rem_q <= 11'd0;
		end

		if (start_try) begin
			total_q <= total_c;
			div_q   <= MAX_DIVISOR;
		end else if (retry) begin
			div_q <= div_q - 8'd1;
		end

		if (tick_acc) begin
			res_q.event_res         <= tk_event;
			res_q.counter_value     <= tk_timer;
			res_q.target_periods    <= target_q;
			res_q.reload_or_compare <= (mode_q == MODE_NORMAL) ? reload_cur : cmp_q;
		end else if (fin_norm) begin
			res_q.event_res         <= 1'b0;
			res_q.counter_value     <= nrm_frac ? (8'd0 - nrm_rem) : timer_q;
			res_q.target_periods    <= nrm_target;
			res_q.reload_or_compare <= 8'd0 - nrm_rem;
		end else if (fin_found || fin_one) begin
			res_q.event_res         <= 1'b0;
			res_q.counter_value     <= timer_q;
			res_q.target_periods    <= fin_found ? quo_q[31:0] : total_q;
			res_q.reload_or_compare <= fin_found ? (div_q - 8'd1) : 8'd0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	// A finished load must never land on a result still waiting
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_norm || fin_found || fin_one) |-> !res_valid_q)
		else $error("load result overwrites a pending beat");

	// Input is only taken with the sequencer at rest
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");

	// Step count stays within one division
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP)
		else $error("divide step count out of range");

	// Divisor trials stay between two and the maximum divisor
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_TRY) |-> (div_q >= 8'd2))
		else $error("divisor under trial below two");

	// A tick beat yields a result on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> res_valid_q)
		else $error("tick beat produced no result");
`endif

endmodule
